// File: sv/smt_pkg.sv
// shared types and constants for the sparse matrix fast transpose block
package smt_pkg;

  // fixed field widths
  localparam int IDX_W = 7;
  localparam int VAL_W = 32;
  localparam int DIM_W = 8;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 2'd1;

  // reset value of both dimension registers
  localparam logic [DIM_W-1:0] DIM_RESET = 8'd128;

  // input beat
  typedef struct packed {
    logic [IDX_W-1:0]        in_row;
    logic [IDX_W-1:0]        in_col;
    logic signed [VAL_W-1:0] in_value;
    logic                    last;
  } in_t;

  // result beat
  typedef struct packed {
    logic [IDX_W-1:0]        out_row;
    logic [IDX_W-1:0]        out_col;
    logic signed [VAL_W-1:0] out_value;
    logic                    out_last;
    logic                    dropped;
  } out_t;

  // one stored triplet, 46 bits
  typedef struct packed {
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
  } ent_t;

  // control strobes of the column memory
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr;
  } col_ctl_t;

  // sequencer phases
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_PREFIX,
    ST_SCATTER,
    ST_EMIT
  } state_t;

endpackage

// File: sv/smt_entry_ram.sv
// triplet memory, one write port and one registered read port
module smt_entry_ram #(
  parameter int DEPTH = 64,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  smt_pkg::ent_t wr_data,
  output smt_pkg::ent_t rd_data
);
  import smt_pkg::*;

  ent_t mem [DEPTH];
  ent_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data registered on rd_en
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: sv/smt_col_ram.sv
// per-column count and slot memory with per-entry valid bits
module smt_col_ram #(
  parameter int DEPTH = 128,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  parameter int DW = 7
) (
  input  logic              clk,
  input  logic              rst_n,
  input  smt_pkg::col_ctl_t ctl,
  input  logic [AW-1:0]     rd_addr,
  input  logic [AW-1:0]     wr_addr,
  input  logic [DW-1:0]     wr_data,
  output logic [DW-1:0]     rd_data
);
  import smt_pkg::*;

  logic [DW-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [DW-1:0] rd_data_r;
  logic rd_vld_r;

  // storage write
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data and its valid bit, sampled together
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else if (ctl.rd_en) begin
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  // valid bits: cleared at once, set on write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ctl.clr) begin
      vld_r <= '0;
    end else if (ctl.wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // an unwritten column reads as zero
  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

// File: sv/sparse_matrix_fast_transpose_top.sv
// sparse matrix fast transpose: load, column prefix sum, scatter and emit
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid / in_ready   | in_data  (row, col, value, last)
//   out     | output    | out_valid / out_ready | out_data (row, col, value, last, dropped)
//   cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// loading takes one beat per cycle; the count update is a read-modify-write of
// the column memory with forwarding from the previous cycle's write.
// after the last beat: a prefix sum over min(num_cols, MAX_DIM) columns, a scatter
// of the n entries and the emit of each result on the transposed memory read port.
// reset is synchronous; the column valid bits clear at once, no sweep is needed.
// input is held off from the last beat until the final result sits in the output
// register; out_ready low stalls the emit phase only.
module sparse_matrix_fast_transpose_top #(
  parameter int MAX_ENTRIES = 64,
  parameter int MAX_DIM = 128
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  smt_pkg::in_t                        in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output smt_pkg::out_t                       out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [smt_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [smt_pkg::DIM_W-1:0]           cfg_data
);
  import smt_pkg::*;

  localparam int CDEPTH = (MAX_DIM < (1 << IDX_W)) ? MAX_DIM : (1 << IDX_W);
  localparam int CAW = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
  localparam int LW = $clog2(CDEPTH + 1);
  localparam int EAW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int ECW = $clog2(MAX_ENTRIES + 1);

  state_t state_r, state_nxt;
  logic [DIM_W-1:0] num_rows_r, num_cols_r;
  logic [ECW-1:0] ecnt_r, ecnt_nxt;
  logic drop_r, drop_nxt;
  logic [ECW-1:0] sum_r, sum_nxt;
  logic [LW-1:0] pf_idx_r, pf_idx_nxt;
  logic [ECW-1:0] ix_r, ix_nxt;

  // load stage two
  logic ld_v_r, ld_ok_r, ld_last_r;
  logic [CAW-1:0] ld_col_r;
  // prefix write stage
  logic pf_v_r, pf_v_nxt;
  logic [CAW-1:0] pf_addr_r;
  // scatter stages
  logic sb_v_r, sb_v_nxt;
  logic sc_v_r, sc_v_nxt;
  ent_t sc_ent_r;
  // previous cycle's column write
  logic fw_v_r;
  logic [CAW-1:0] fw_addr_r;
  logic [ECW-1:0] fw_data_r;
  // emit
  logic rd_pend_r, rd_pend_nxt;
  logic rd_last_r, rd_last_nxt;
  logic out_v_r, out_v_nxt;
  out_t out_data_r;

  logic in_acc, in_ok, clear_load;
  logic [LW-1:0] lim;
  logic pf_issue, sc_issue, em_issue;
  logic [ECW-1:0] ld_cnt, sc_slot;

  col_ctl_t col_ctl;
  logic [CAW-1:0] col_rd_addr, col_wr_addr;
  logic [ECW-1:0] col_wr_data, col_rd;
  logic e_wr_en, e_rd_en, t_wr_en, t_rd_en;
  logic [EAW-1:0] e_wr_addr, e_rd_addr, t_wr_addr, t_rd_addr;
  ent_t e_wr_data, e_rd, t_wr_data, t_rd;

  // memories
  smt_entry_ram #(.DEPTH(MAX_ENTRIES), .AW(EAW)) u_entry (
    .clk     (clk),
    .rd_en   (e_rd_en),
    .rd_addr (e_rd_addr),
    .wr_en   (e_wr_en),
    .wr_addr (e_wr_addr),
    .wr_data (e_wr_data),
    .rd_data (e_rd)
  );

  smt_entry_ram #(.DEPTH(MAX_ENTRIES), .AW(EAW)) u_trans (
    .clk     (clk),
    .rd_en   (t_rd_en),
    .rd_addr (t_rd_addr),
    .wr_en   (t_wr_en),
    .wr_addr (t_wr_addr),
    .wr_data (t_wr_data),
    .rd_data (t_rd)
  );

  smt_col_ram #(.DEPTH(CDEPTH), .AW(CAW), .DW(ECW)) u_col (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (col_ctl),
    .rd_addr (col_rd_addr),
    .wr_addr (col_wr_addr),
    .wr_data (col_wr_data),
    .rd_data (col_rd)
  );

  // handshakes and range check
  assign cfg_ready = 1'b1;
  assign in_ready = (state_r == ST_LOAD) && !(ld_v_r && ld_last_r);
  assign in_acc = in_valid && in_ready;
  assign in_ok = ({1'b0, in_data.in_row} < {1'b0, num_rows_r})
              && (int'(in_data.in_row) < MAX_DIM)
              && ({1'b0, in_data.in_col} < {1'b0, num_cols_r})
              && (int'(in_data.in_col) < MAX_DIM)
              && (ecnt_r < ECW'(MAX_ENTRIES));

  // columns covered by the prefix pass
  always_comb begin
    if ({1'b0, num_cols_r} > 9'(CDEPTH)) begin
      lim = LW'(CDEPTH);
    end else begin
      lim = LW'(num_cols_r);
    end
  end

  // read-modify-write values with forwarding
  assign ld_cnt = (fw_v_r && fw_addr_r == ld_col_r) ? fw_data_r : col_rd;
  assign sc_slot = (fw_v_r && fw_addr_r == sc_ent_r.col[CAW-1:0]) ? fw_data_r : col_rd;

  // entry store write while loading
  assign e_wr_en = in_acc && in_ok;
  assign e_wr_addr = ecnt_r[EAW-1:0];
  assign e_wr_data = '{row: in_data.in_row, col: in_data.in_col, value: in_data.in_value};

  // transposed store write from scatter stage
  assign t_wr_addr = sc_slot[EAW-1:0];
  assign t_wr_data = '{row: sc_ent_r.col, col: sc_ent_r.row, value: sc_ent_r.value};

  assign pf_issue = (pf_idx_r < lim);
  assign sc_issue = (ix_r < ecnt_r);
  assign em_issue = (ix_r < ecnt_r) && !rd_pend_r && (!out_v_r || out_ready);

  // sequencer: next state and memory controls
  always_comb begin
    state_nxt = state_r;
    ecnt_nxt = ecnt_r;
    drop_nxt = drop_r;
    sum_nxt = sum_r;
    pf_idx_nxt = pf_idx_r;
    ix_nxt = ix_r;
    pf_v_nxt = 1'b0;
    sb_v_nxt = 1'b0;
    sc_v_nxt = sb_v_r;
    rd_pend_nxt = 1'b0;
    rd_last_nxt = rd_last_r;
    out_v_nxt = out_v_r && !out_ready;
    clear_load = 1'b0;
    col_ctl = '0;
    col_rd_addr = '0;
    col_wr_addr = '0;
    col_wr_data = '0;
    e_rd_en = 1'b0;
    e_rd_addr = ix_r[EAW-1:0];
    t_wr_en = 1'b0;
    t_rd_en = 1'b0;
    t_rd_addr = ix_r[EAW-1:0];
    unique case (state_r)
      ST_LOAD: begin
        // stage one: keep entry, fetch its column count
        if (in_acc && in_ok) begin
          col_ctl.rd_en = 1'b1;
          col_rd_addr = in_data.in_col[CAW-1:0];
          ecnt_nxt = ECW'(ecnt_r + 1'b1);
        end
        if (in_acc && !in_ok) begin
          drop_nxt = 1'b1;
        end
        // stage two: bump the count
        if (ld_v_r && ld_ok_r) begin
          col_ctl.wr_en = 1'b1;
          col_wr_addr = ld_col_r;
          col_wr_data = ECW'(ld_cnt + 1'b1);
        end
        if (ld_v_r && ld_last_r) begin
          if (ecnt_r == '0) begin
            clear_load = 1'b1;
          end else begin
            state_nxt = ST_PREFIX;
            pf_idx_nxt = '0;
            sum_nxt = '0;
          end
        end
      end
      ST_PREFIX: begin
        // exclusive prefix sum, count replaced by first slot
        if (pf_issue) begin
          col_ctl.rd_en = 1'b1;
          col_rd_addr = pf_idx_r[CAW-1:0];
          pf_v_nxt = 1'b1;
          pf_idx_nxt = LW'(pf_idx_r + 1'b1);
        end
        if (pf_v_r) begin
          col_ctl.wr_en = 1'b1;
          col_wr_addr = pf_addr_r;
          col_wr_data = sum_r;
          sum_nxt = ECW'(sum_r + col_rd);
        end
        if (!pf_issue && !pf_v_r) begin
          state_nxt = ST_SCATTER;
          ix_nxt = '0;
        end
      end
      ST_SCATTER: begin
        // stage a: read entry
        if (sc_issue) begin
          e_rd_en = 1'b1;
          sb_v_nxt = 1'b1;
          ix_nxt = ECW'(ix_r + 1'b1);
        end
        // stage b: fetch slot of its column
        if (sb_v_r) begin
          col_ctl.rd_en = 1'b1;
          col_rd_addr = e_rd.col[CAW-1:0];
        end
        // stage c: place entry, advance slot
        if (sc_v_r) begin
          col_ctl.wr_en = 1'b1;
          col_wr_addr = sc_ent_r.col[CAW-1:0];
          col_wr_data = ECW'(sc_slot + 1'b1);
          t_wr_en = 1'b1;
        end
        if (!sc_issue && !sb_v_r && !sc_v_r) begin
          state_nxt = ST_EMIT;
          ix_nxt = '0;
        end
      end
      ST_EMIT: begin
        // read the next result when the output register frees up
        if (em_issue) begin
          t_rd_en = 1'b1;
          rd_pend_nxt = 1'b1;
          rd_last_nxt = (ECW'(ix_r + 1'b1) == ecnt_r);
          ix_nxt = ECW'(ix_r + 1'b1);
        end
        if (rd_pend_r) begin
          out_v_nxt = 1'b1;
          if (rd_last_r) begin
            clear_load = 1'b1;
            state_nxt = ST_LOAD;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
    // start a fresh matrix
    if (clear_load) begin
      ecnt_nxt = '0;
      drop_nxt = 1'b0;
      col_ctl.clr = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      ecnt_r <= '0;
      drop_r <= 1'b0;
      sum_r <= '0;
      pf_idx_r <= '0;
      ix_r <= '0;
      ld_v_r <= 1'b0;
      pf_v_r <= 1'b0;
      sb_v_r <= 1'b0;
      sc_v_r <= 1'b0;
      fw_v_r <= 1'b0;
      rd_pend_r <= 1'b0;
      rd_last_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ecnt_r <= ecnt_nxt;
      drop_r <= drop_nxt;
      sum_r <= sum_nxt;
      pf_idx_r <= pf_idx_nxt;
      ix_r <= ix_nxt;
      ld_v_r <= in_acc;
      pf_v_r <= pf_v_nxt;
      sb_v_r <= sb_v_nxt;
      sc_v_r <= sc_v_nxt;
      fw_v_r <= col_ctl.wr_en;
      rd_pend_r <= rd_pend_nxt;
      rd_last_r <= rd_last_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_rows_r <= DIM_RESET;
      num_cols_r <= DIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_NUM_ROWS) begin
        num_rows_r <= cfg_data;
      end else if (cfg_index == REG_NUM_COLS) begin
        num_cols_r <= cfg_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ld_ok_r <= in_ok;
      ld_last_r <= in_data.last;
      ld_col_r <= in_data.in_col[CAW-1:0];
    end
    if (pf_issue) begin
      pf_addr_r <= pf_idx_r[CAW-1:0];
    end
    if (sb_v_r) begin
      sc_ent_r <= e_rd;
    end
    fw_addr_r <= col_wr_addr;
    fw_data_r <= col_wr_data;
    if (rd_pend_r) begin
      out_data_r <= '{out_row: t_rd.row, out_col: t_rd.col, out_value: t_rd.value,
                      out_last: rd_last_r, dropped: drop_r};
    end
  end

  assign out_valid = out_v_r;
  assign out_data = out_data_r;

endmodule

// File: sv/smt_checker.sv
// port-level checker for the transpose block and its bind
module smt_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input smt_pkg::in_t                  in_data,
  input logic                          out_valid,
  input logic                          out_ready,
  input smt_pkg::out_t                 out_data,
  input logic                          cfg_valid,
  input logic                          cfg_ready,
  input logic [smt_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [smt_pkg::DIM_W-1:0]     cfg_data
);
  import smt_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // reset empties the output register
  a_out_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // no new matrix is taken while the current one is still being emitted
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.out_last |-> !in_ready)
    else $error("input taken in the middle of a result run");

  // dropped is the same on every beat of one run
  a_drop_steady: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.out_last
      |=> !out_valid || (out_data.dropped == $past(out_data.dropped)))
    else $error("dropped flag changed within a run");

endmodule

bind sparse_matrix_fast_transpose_top smt_checker u_smt_checker (.*);
